// File: rtl/dbec_pkg.sv
package dbec_pkg;

    localparam int NOW_W      = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MS_W       = 16;
    localparam int MODE_W     = 2;

    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [MS_W-1:0] DEBOUNCE_RST   = MS_W'(0);
    localparam logic [MS_W-1:0] LONG_PRESS_RST = MS_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_COUNT_MODE = 2'd1,
        REG_LONG_PRESS = 2'd2
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        CM_FALL = 2'd0,
        CM_RISE = 2'd1,
        CM_BOTH = 2'd2,
        CM_NONE = 2'd3
    } t_count_mode;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

endpackage

// File: rtl/dbec_in_if.sv
interface dbec_in_if
    import dbec_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic             raw_level;
    logic [NOW_W-1:0] now_ms;

    modport source(output valid, cmd, raw_level, now_ms, input ready);
    modport sink(input valid, cmd, raw_level, now_ms, output ready);
endinterface

// File: rtl/dbec_out_if.sv
interface dbec_out_if
    import dbec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               steady_level;
    logic               pressed;
    logic               released;
    logic               long_pressed;
    logic [TOTAL_W-1:0] edge_total;

    modport source(output valid, steady_level, pressed, released, long_pressed, edge_total,
                   input ready);
    modport sink(input valid, steady_level, pressed, released, long_pressed, edge_total,
                 output ready);
endinterface

// File: rtl/debounced_button_edge_counter.sv
// Debounced active-low button with a steady-edge counter.
// Input channel i_in carries one beat per item: cmd (sample or clear count),
// raw_level and a wrapping millisecond timestamp now_ms. Output channel o_out
// returns exactly one beat per input beat: steady level, pressed and released
// pulses, long-press flag and the edge count after that item.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 debounce time, 1 count mode, 2 long-press time; write while idle.
// Latency: a beat accepted at one edge is shown on o_out from the next cycle.
// Throughput: one item per cycle while o_out.ready is high; the whole update
// is one compare/subtract and one increment ahead of the result register.
// Stall: the result register holds its beat while o_out.ready is low, and
// i_in.ready drops until the beat is taken, so nothing is lost or repeated.
// Reset (synchronous, i_rst_n low): raw and steady levels idle high, time
// stamp and count zero, debounce 0 ms, count mode falling, long press
// 1000 ms, output channel empty.
module debounced_button_edge_counter
    import dbec_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dbec_in_if.sink               i_in,
    dbec_out_if.source            o_out
);

    logic [MS_W-1:0]       r_debounce;
    t_count_mode           r_mode;
    logic [MS_W-1:0]       r_long_press;

    logic [TIME_BITS-1:0]  r_stamp;
    logic                  r_raw_seen;
    logic                  r_steady;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_out_valid;
    logic                  r_out_steady;
    logic                  r_out_pressed;
    logic                  r_out_released;
    logic                  r_out_long;
    logic [COUNT_BITS-1:0] r_out_count;

    logic                  in_fire;
    logic                  is_clear;
    logic [TIME_BITS-1:0]  now_t;
    logic                  raw_change;
    logic [TIME_BITS-1:0]  n_stamp;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  n_steady;
    logic                  n_pressed;
    logic                  n_released;
    logic                  n_long;
    logic                  count_hit;
    logic [COUNT_BITS-1:0] n_count;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign is_clear   = (t_cmd'(i_in.cmd) == CMD_CLEAR);
    assign now_t      = TIME_BITS'(i_in.now_ms);

    always_comb begin
        raw_change = !is_clear && (i_in.raw_level != r_raw_seen);
        n_stamp    = raw_change ? now_t : r_stamp;
        elapsed    = now_t - n_stamp;
        n_steady   = r_steady;
        if (!is_clear && (elapsed >= TIME_BITS'(r_debounce))) begin
            n_steady = i_in.raw_level;
        end
        n_pressed  = !is_clear && r_steady && !n_steady;
        n_released = !is_clear && !r_steady && n_steady;
        n_long     = !n_steady && (elapsed >= TIME_BITS'(r_long_press));
        unique case (r_mode)
            CM_FALL: count_hit = n_pressed;
            CM_RISE: count_hit = n_released;
            CM_BOTH: count_hit = n_pressed || n_released;
            CM_NONE: count_hit = 1'b0;
            default: count_hit = 1'b0;
        endcase
        if (is_clear) begin
            n_count = '0;
        end else if (count_hit) begin
            n_count = r_count + COUNT_BITS'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_mode       <= CM_FALL;
            r_long_press <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                REG_COUNT_MODE: r_mode       <= t_count_mode'(i_cfg_data[MODE_W-1:0]);
                REG_LONG_PRESS: r_long_press <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp     <= '0;
            r_raw_seen  <= 1'b1;
            r_steady    <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_stamp     <= n_stamp;
                r_raw_seen  <= is_clear ? r_raw_seen : i_in.raw_level;
                r_steady    <= n_steady;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_steady   <= n_steady;
            r_out_pressed  <= n_pressed;
            r_out_released <= n_released;
            r_out_long     <= n_long;
            r_out_count    <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.steady_level = r_out_steady;
    assign o_out.pressed      = r_out_pressed;
    assign o_out.released     = r_out_released;
    assign o_out.long_pressed = r_out_long;
    assign o_out.edge_total   = TOTAL_W'(r_out_count);

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_pressed && r_out_released))
        else $error("pressed and released in one beat");

    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pressed || r_out_long)) |-> !r_out_steady)
        else $error("press flag with steady level high");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_clear) |=> (r_count == '0) && (r_out_count == '0))
        else $error("count not cleared");

    a_steady_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_clear) |=> (r_steady == $past(r_steady)))
        else $error("steady level moved on clear");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_clear && !n_pressed && !n_released) |=> $stable(r_count))
        else $error("count moved without an edge");

endmodule

// File: test/testbench.sv
module testbench;
    import dbec_pkg::*;

    typedef struct {
        t_cmd             cmd;
        logic             raw;
        logic [NOW_W-1:0] stamp;
    } t_sample;

    typedef struct {
        logic               steady;
        logic               pressed;
        logic               released;
        logic               long_hold;
        logic [TOTAL_W-1:0] total;
    } t_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dbec_in_if  in_ch ();
    dbec_out_if out_ch ();

    debounced_button_edge_counter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_sample pending_q[$];
    t_status status_q[$];
    int      n_queued       = 0;
    int      n_checked      = 0;
    int      n_errors       = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    logic    in_taken       = 1'b0;

    logic [MS_W-1:0]    debounce_cfg = DEBOUNCE_RST;
    t_count_mode        mode_cfg     = CM_FALL;
    logic [MS_W-1:0]    long_cfg     = LONG_PRESS_RST;
    logic [NOW_W-1:0]   change_ms    = '0;
    logic               raw_last     = 1'b1;
    logic               level_now    = 1'b1;
    logic               level_prev   = 1'b1;
    logic [TOTAL_W-1:0] edge_cnt     = '0;

    logic [NOW_W-1:0]   wall_ms      = '0;
    logic               btn_level    = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_status advance_button(t_sample s);
        t_status          r;
        logic [NOW_W-1:0] held;
        r.pressed  = 1'b0;
        r.released = 1'b0;
        if (s.cmd == CMD_CLEAR) begin
            edge_cnt = '0;
        end else begin
            if (s.raw != raw_last) begin
                change_ms = s.stamp;
                raw_last  = s.raw;
            end
            level_prev = level_now;
            held = s.stamp - change_ms;
            if (held >= NOW_W'(debounce_cfg)) begin
                level_now = s.raw;
            end
            r.pressed  = level_prev && !level_now;
            r.released = !level_prev && level_now;
            if ((mode_cfg == CM_FALL && r.pressed) || (mode_cfg == CM_RISE && r.released)
                    || (mode_cfg == CM_BOTH && (r.pressed || r.released))) begin
                edge_cnt = edge_cnt + TOTAL_W'(1);
            end
        end
        held        = s.stamp - change_ms;
        r.steady    = level_now;
        r.long_hold = !level_now && (held >= NOW_W'(long_cfg));
        r.total     = edge_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [NOW_W-1:0] want,
                                        logic [NOW_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void queue_sample(t_cmd c, logic r, logic [NOW_W-1:0] t);
        t_sample s;
        s.cmd   = c;
        s.raw   = r;
        s.stamp = t;
        pending_q.push_back(s);
        n_queued++;
    endfunction

    always @(negedge i_clk) begin : driver
        t_sample s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s = pending_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.cmd       <= s.cmd;
                in_ch.raw_level <= s.raw;
                in_ch.now_ms    <= s.stamp;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= !i_rst_n || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_sample s;
        t_status want;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    n_errors++;
                end else begin
                    want = status_q.pop_front();
                    check_field("steady_level", NOW_W'(want.steady),
                                NOW_W'(out_ch.steady_level));
                    check_field("pressed", NOW_W'(want.pressed), NOW_W'(out_ch.pressed));
                    check_field("released", NOW_W'(want.released), NOW_W'(out_ch.released));
                    check_field("long_pressed", NOW_W'(want.long_hold),
                                NOW_W'(out_ch.long_pressed));
                    check_field("edge_total", NOW_W'(want.total), NOW_W'(out_ch.edge_total));
                    n_checked++;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                s.cmd   = t_cmd'(in_ch.cmd);
                s.raw   = in_ch.raw_level;
                s.stamp = in_ch.now_ms;
                status_q.push_back(advance_button(s));
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   debounce_cfg = val[MS_W-1:0];
            REG_COUNT_MODE: mode_cfg = t_count_mode'(val[MODE_W-1:0]);
            REG_LONG_PRESS: long_cfg = val[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued) begin
            @(negedge i_clk);
        end
    endtask

    // mostly press/release episodes with bounce, plus noise and clears
    task automatic queue_random(input int count);
        int stop;
        int pick;
        int bounce_span;
        int hold_span;
        stop        = n_queued + count;
        bounce_span = int'(debounce_cfg) / 2 + 1;
        hold_span   = (int'(debounce_cfg) + int'(long_cfg)) / 2 + 2;
        wall_ms     = $urandom;
        while (n_queued < stop) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                queue_sample(CMD_CLEAR, 1'($urandom), wall_ms);
            end else if (pick < 12) begin
                queue_sample(CMD_SAMPLE, 1'($urandom), $urandom);
            end else begin
                btn_level = !btn_level;
                repeat ($urandom_range(4)) begin
                    wall_ms += $urandom_range(bounce_span);
                    queue_sample(CMD_SAMPLE, 1'($urandom), wall_ms);
                end
                repeat ($urandom_range(4, 1)) begin
                    wall_ms += $urandom_range(hold_span);
                    queue_sample(CMD_SAMPLE, btn_level, wall_ms);
                end
            end
        end
    endtask

    initial begin : stimulus
        int          dbc[8]   = '{10, 0, 65535, 3, 25, 1, 100, 7};
        int          longs[8] = '{50, 0, 65535, 20, 200, 1, 1000, 40};
        t_count_mode modes[8] = '{CM_BOTH, CM_RISE, CM_FALL, CM_NONE,
                                  CM_BOTH, CM_FALL, CM_RISE, CM_BOTH};
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no debounce, falling edges, 1000 ms long press
        queue_sample(CMD_SAMPLE, 1'b1, 32'd0);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd5);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd1004);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd1005);
        queue_sample(CMD_CLEAR, 1'b1, 32'd2000);
        queue_sample(CMD_SAMPLE, 1'b1, 32'd2001);
        queue_sample(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
        queue_sample(CMD_CLEAR, 1'b0, 32'hFFFF_FFFF);
        queue_sample(CMD_SAMPLE, 1'b0, 32'h0000_03E7);
        queue_sample(CMD_SAMPLE, 1'b1, 32'h0000_0400);
        wait_drained();

        write_reg(REG_DEBOUNCE, 16'd20);
        write_reg(REG_COUNT_MODE, CFG_DATA_W'(CM_BOTH));
        write_reg(REG_LONG_PRESS, 16'd0);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd100);
        queue_sample(CMD_SAMPLE, 1'b1, 32'd105);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd110);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd129);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd130);
        queue_sample(CMD_SAMPLE, 1'b1, 32'd131);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd140);
        queue_sample(CMD_SAMPLE, 1'b0, 32'd150);
        queue_sample(CMD_SAMPLE, 1'b1, 32'hFFFF_FFF0);
        queue_sample(CMD_SAMPLE, 1'b1, 32'h0000_0004);
        queue_sample(CMD_CLEAR, 1'b0, 32'h0000_0005);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_DEBOUNCE, CFG_DATA_W'(dbc[p]));
            write_reg(REG_COUNT_MODE, {14'($urandom), 2'(modes[p])});
            write_reg(REG_LONG_PRESS, CFG_DATA_W'(longs[p]));
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            queue_random(160);
            wait_drained();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (20) @(negedge i_clk);
        if (n_errors == 0 && status_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
